FILE: hw/rtl/ssrm_pkg.sv
// ssrm_pkg: shared types and constants of the scan sector/range mask.
// No dependencies; used by ssrm_cfg, ssrm_front, ssrm_back and the top level.
package ssrm_pkg;

    localparam int ANGLE_W = 16;
    localparam int RANGE_W = 16;
    localparam int CFG_W = 16;
    localparam int CFG_IDX_W = 3;
    localparam int COUNT_W = 2;

    localparam int MAX_SECTORS_DEF = 2;
    localparam int SEC_CFG_SLOTS = 2;
    localparam int MID_DEPTH = 2;

    localparam logic CMD_HEADER = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_RANGE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RANGE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SECTOR_COUNT = 3'd2;
    localparam int REG_SEC0_START = 3;

    localparam logic [RANGE_W-1:0] MIN_RANGE_RST = 16'd50;
    localparam logic [RANGE_W-1:0] MAX_RANGE_RST = 16'd30000;
    localparam logic [RANGE_W-1:0] RANGE_INF = 16'hFFFF;

    typedef struct packed {
        logic [RANGE_W-1:0] min_range_mm;
        logic [RANGE_W-1:0] max_range_mm;
        logic [COUNT_W-1:0] sector_count;
    } cfg_t;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] angle;
        logic [RANGE_W-1:0]        range_mm;
    } mid_t;

endpackage

FILE: hw/rtl/ssrm_fifo.sv
// ssrm_fifo: small register-based queue between the front and back parts.
// Depends on nothing; width and depth come from the instantiating module.
module ssrm_fifo #(
    parameter int W = 32,
    parameter int DEPTH = 2
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] wdata,
    output logic         full,
    input  logic         pop,
    output logic [W-1:0] rdata,
    output logic         empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          push_ok;
    logic          pop_ok;

    assign full = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = mem_reg[rd_ptr_reg];
    assign push_ok = push && !full;
    assign pop_ok = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (push_ok)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_ok)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push_ok && !pop_ok)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop_ok && !push_ok)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

FILE: hw/rtl/ssrm_cfg.sv
// ssrm_cfg: configuration registers (range bounds, sector count, sectors).
// Depends on ssrm_pkg.
module ssrm_cfg #(
    parameter int MAX_SECTORS = ssrm_pkg::MAX_SECTORS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [ssrm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ssrm_pkg::CFG_W-1:0]         cfg_wdata,
    output ssrm_pkg::cfg_t                     cfg,
    output logic signed [ssrm_pkg::ANGLE_W-1:0] sec_start [MAX_SECTORS],
    output logic signed [ssrm_pkg::ANGLE_W-1:0] sec_end [MAX_SECTORS]
);

    ssrm_pkg::cfg_t cfg_reg;

    assign cfg = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_range_mm <= ssrm_pkg::MIN_RANGE_RST;
            cfg_reg.max_range_mm <= ssrm_pkg::MAX_RANGE_RST;
            cfg_reg.sector_count <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ssrm_pkg::REG_MIN_RANGE:    cfg_reg.min_range_mm <= cfg_wdata;
                ssrm_pkg::REG_MAX_RANGE:    cfg_reg.max_range_mm <= cfg_wdata;
                ssrm_pkg::REG_SECTOR_COUNT:
                    cfg_reg.sector_count <= cfg_wdata[ssrm_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    for (genvar s = 0; s < MAX_SECTORS; s++)
    begin : g_sec
        if (s < ssrm_pkg::SEC_CFG_SLOTS)
        begin : g_rw
            localparam logic [ssrm_pkg::CFG_IDX_W-1:0] START_IDX =
                ssrm_pkg::CFG_IDX_W'(ssrm_pkg::REG_SEC0_START + 2 * s);
            localparam logic [ssrm_pkg::CFG_IDX_W-1:0] END_IDX =
                ssrm_pkg::CFG_IDX_W'(ssrm_pkg::REG_SEC0_START + 2 * s + 1);

            logic signed [ssrm_pkg::ANGLE_W-1:0] start_reg;
            logic signed [ssrm_pkg::ANGLE_W-1:0] end_reg;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    start_reg <= '0;
                    end_reg <= '0;
                end
                else if (cfg_we)
                begin
                    if (cfg_index == START_IDX)
                    begin
                        start_reg <= cfg_wdata;
                    end
                    if (cfg_index == END_IDX)
                    begin
                        end_reg <= cfg_wdata;
                    end
                end
            end

            assign sec_start[s] = start_reg;
            assign sec_end[s] = end_reg;
        end
        else
        begin : g_fixed
            // no register slot: tied to zero
            assign sec_start[s] = '0;
            assign sec_end[s] = '0;
        end
    end

endmodule

FILE: hw/rtl/ssrm_front.sv
// ssrm_front: accepts items, tracks the sample angle, queues samples.
// Depends on ssrm_pkg.
module ssrm_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic                               cmd,
    input  logic signed [ssrm_pkg::ANGLE_W-1:0] start_angle,
    input  logic signed [ssrm_pkg::ANGLE_W-1:0] step_angle,
    input  logic [ssrm_pkg::RANGE_W-1:0]       range_mm,
    input  logic                               q_full,
    output logic                               q_push,
    output ssrm_pkg::mid_t                     q_data
);

    logic signed [ssrm_pkg::ANGLE_W-1:0] angle_reg, angle_next;
    logic signed [ssrm_pkg::ANGLE_W-1:0] step_reg, step_next;
    logic                                accept;

    assign full = q_full;
    assign accept = push && !q_full;
    assign q_push = accept && (cmd == ssrm_pkg::CMD_SAMPLE);
    assign q_data.angle = angle_reg;
    assign q_data.range_mm = range_mm;

    always_comb
    begin
        angle_next = angle_reg;
        step_next = step_reg;
        if (accept)
        begin
            if (cmd == ssrm_pkg::CMD_HEADER)
            begin
                angle_next = start_angle;
                step_next = step_angle;
            end
            else
            begin
                // wraps modulo 2pi
                angle_next = angle_reg + step_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_reg <= '0;
            step_reg <= '0;
        end
        else
        begin
            angle_reg <= angle_next;
            step_reg <= step_next;
        end
    end

endmodule

FILE: hw/rtl/ssrm_back.sv
// ssrm_back: sector and range tests on queued samples, result register.
// Depends on ssrm_pkg.
module ssrm_back #(
    parameter int MAX_SECTORS = ssrm_pkg::MAX_SECTORS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               q_empty,
    input  ssrm_pkg::mid_t                     q_data,
    output logic                               q_pop,
    input  ssrm_pkg::cfg_t                     cfg,
    input  logic signed [ssrm_pkg::ANGLE_W-1:0] sec_start [MAX_SECTORS],
    input  logic signed [ssrm_pkg::ANGLE_W-1:0] sec_end [MAX_SECTORS],
    input  logic                               pop,
    output logic                               empty,
    output logic [ssrm_pkg::RANGE_W-1:0]       range_out,
    output logic                               masked
);

    logic                           valid_reg;
    logic [ssrm_pkg::RANGE_W-1:0]   range_reg;
    logic                           masked_reg;
    logic [MAX_SECTORS-1:0]         sec_hit;
    logic                           range_bad;
    logic                           hit;

    for (genvar i = 0; i < MAX_SECTORS; i++)
    begin : g_hit
        logic in_sec;

        always_comb
        begin
            if (sec_start[i] <= sec_end[i])
            begin
                in_sec = (q_data.angle >= sec_start[i]) && (q_data.angle <= sec_end[i]);
            end
            else
            begin
                // wraps across pi
                in_sec = (q_data.angle >= sec_start[i]) || (q_data.angle <= sec_end[i]);
            end
        end

        assign sec_hit[i] = in_sec && (int'(cfg.sector_count) > i);
    end

    assign range_bad = (q_data.range_mm < cfg.min_range_mm) ||
                       (q_data.range_mm > cfg.max_range_mm);
    assign hit = range_bad || (|sec_hit);

    assign q_pop = !q_empty && (!valid_reg || pop);
    assign empty = !valid_reg;
    assign range_out = range_reg;
    assign masked = masked_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (q_pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            range_reg <= hit ? ssrm_pkg::RANGE_INF : q_data.range_mm;
            masked_reg <= hit;
        end
    end

endmodule

FILE: hw/rtl/scan_sector_range_mask.sv
// scan_sector_range_mask: top level of the scan sector/range mask.
// A sample's result passes through the middle queue and the result register to the outputs.
// Throughput: one item per cycle while the middle queue is not full, set by the angle adder and the parallel compares.
// Headers give no result; full rises only when the two-entry middle queue fills.
// Reset: registers to their defaults, angle and step to zero, queues empty.
// Depends on ssrm_pkg, ssrm_cfg, ssrm_front, ssrm_fifo, ssrm_back.
module scan_sector_range_mask #(
    parameter int MAX_SECTORS = ssrm_pkg::MAX_SECTORS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic                               cmd,
    input  logic signed [ssrm_pkg::ANGLE_W-1:0] start_angle,
    input  logic signed [ssrm_pkg::ANGLE_W-1:0] step_angle,
    input  logic [ssrm_pkg::RANGE_W-1:0]       range_mm,
    output logic                               empty,
    input  logic                               pop,
    output logic [ssrm_pkg::RANGE_W-1:0]       range_out,
    output logic                               masked,
    input  logic                               cfg_we,
    input  logic [ssrm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ssrm_pkg::CFG_W-1:0]         cfg_wdata
);

    ssrm_pkg::cfg_t                     cfg;
    logic signed [ssrm_pkg::ANGLE_W-1:0] sec_start [MAX_SECTORS];
    logic signed [ssrm_pkg::ANGLE_W-1:0] sec_end [MAX_SECTORS];
    logic                               q_push;
    logic                               q_full;
    logic                               q_pop;
    logic                               q_empty;
    ssrm_pkg::mid_t                     q_wdata;
    ssrm_pkg::mid_t                     q_rdata;

    ssrm_cfg #(
        .MAX_SECTORS(MAX_SECTORS)
    ) u_cfg (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .cfg(cfg),
        .sec_start(sec_start),
        .sec_end(sec_end)
    );

    ssrm_front u_front (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .cmd(cmd),
        .start_angle(start_angle),
        .step_angle(step_angle),
        .range_mm(range_mm),
        .q_full(q_full),
        .q_push(q_push),
        .q_data(q_wdata)
    );

    ssrm_fifo #(
        .W($bits(ssrm_pkg::mid_t)),
        .DEPTH(ssrm_pkg::MID_DEPTH)
    ) u_mid_q (
        .clk(clk),
        .rst_n(rst_n),
        .push(q_push),
        .wdata(q_wdata),
        .full(q_full),
        .pop(q_pop),
        .rdata(q_rdata),
        .empty(q_empty)
    );

    ssrm_back #(
        .MAX_SECTORS(MAX_SECTORS)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .q_empty(q_empty),
        .q_data(q_rdata),
        .q_pop(q_pop),
        .cfg(cfg),
        .sec_start(sec_start),
        .sec_end(sec_end),
        .pop(pop),
        .empty(empty),
        .range_out(range_out),
        .masked(masked)
    );

endmodule
